@@ hw/rtl/joystick_pose_integrator_assert.svh @@
// Assertion macros shared by the checker of the pose integrator.
`ifndef JOYSTICK_POSE_INTEGRATOR_ASSERT_SVH
`define JOYSTICK_POSE_INTEGRATOR_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define JPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define JPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/jpi_pkg.sv @@
`default_nettype none
package jpi_pkg;

    typedef logic signed [33:0] t_q30;
    typedef logic signed [67:0] t_prod;
    typedef logic signed [21:0] t_ang;

    localparam t_ang PI_Q17      = 22'sd411775;
    localparam t_ang TWO_PI_Q17  = 22'sd823550;
    localparam t_ang HALF_PI_Q17 = 22'sd205887;
    localparam t_ang PI_Q16      = 22'sd205887;
    localparam t_ang TWO_PI_Q16  = 22'sd411775;

    localparam t_q30 ONE_Q30 = 34'sh0_4000_0000;
    localparam t_q30 NEG_ONE_Q30 = -34'sh0_4000_0000;

    localparam logic [15:0] STEP_TIME_RESET = 16'd1311;

    // Configuration register indexes.
    localparam logic [2:0] REG_STEP_TIME    = 3'd0;
    localparam logic [2:0] REG_INIT_X       = 3'd1;
    localparam logic [2:0] REG_INIT_Y       = 3'd2;
    localparam logic [2:0] REG_INIT_Z       = 3'd3;
    localparam logic [2:0] REG_INIT_HEADING = 3'd4;

    // Horner steps: four for the sine series, five for the cosine series.
    localparam logic [3:0] LAST_SIN_STEP = 4'd3;
    localparam logic [3:0] LAST_COS_STEP = 4'd8;

    // Each Horner division by 72, 42, 20, 6, 90, 56, 30, 12 or 2 is done on the
    // magnitude: a right shift by the power-of-two factor, then a multiply by the
    // rounded-up reciprocal of the odd factor and a right shift. This is exact for
    // magnitudes below 2^33.
    function automatic logic [1:0] horner_pre(input logic [3:0] step);
        logic [1:0] s;
        case (step)
            4'd0: s = 2'd3;
            4'd1: s = 2'd1;
            4'd2: s = 2'd2;
            4'd3: s = 2'd1;
            4'd4: s = 2'd1;
            4'd5: s = 2'd3;
            4'd6: s = 2'd1;
            4'd7: s = 2'd2;
            4'd8: s = 2'd1;
            default: s = 2'd1;
        endcase
        return s;
    endfunction

    function automatic t_q30 horner_recip(input logic [3:0] step);
        t_q30 m;
        case (step)
            4'd0: m = 34'sd1908874354;
            4'd1: m = 34'sd6544712071;
            4'd2: m = 34'sd3435973837;
            4'd3: m = 34'sd5726623062;
            4'd4: m = 34'sd6108397933;
            4'd5: m = 34'sd1227133514;
            4'd6: m = 34'sd4581298450;
            4'd7: m = 34'sd2863311531;
            4'd8: m = 34'sd1;
            default: m = 34'sd1;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] horner_post(input logic [3:0] step);
        logic [5:0] k;
        case (step)
            4'd0: k = 6'd34;
            4'd1: k = 6'd37;
            4'd2: k = 6'd34;
            4'd3: k = 6'd34;
            4'd4: k = 6'd38;
            4'd5: k = 6'd33;
            4'd6: k = 6'd36;
            4'd7: k = 6'd33;
            4'd8: k = 6'd0;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    // Q8.60 product scaled back to Q4.30, truncating toward zero.
    function automatic t_q30 mul_q30(input t_prod p);
        t_prod r;
        if (p < 0) begin
            r = (p + 68'sd1073741823) >>> 30;
        end else begin
            r = p >>> 30;
        end
        return r[33:0];
    endfunction

    function automatic logic signed [31:0] clamp_q30(input t_q30 v);
        logic signed [31:0] r;
        if (v > ONE_Q30) begin
            r = 32'sh4000_0000;
        end else if (v < NEG_ONE_Q30) begin
            r = -32'sh4000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // One wrap into plus or minus pi, kept to 20 bits.
    function automatic logic signed [19:0] wrap_once(input t_ang a);
        t_ang r;
        r = (a > PI_Q16) ? a - TWO_PI_Q16 : a;
        r = (r < -PI_Q16) ? r + TWO_PI_Q16 : r;
        return r[19:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/jpi_in_if.sv @@
`default_nettype none
interface jpi_in_if;
    logic               valid;
    logic               ready;
    logic               joy_present;
    logic signed [15:0] axis_forward;
    logic signed [15:0] axis_left;
    logic signed [15:0] axis_up;
    logic signed [15:0] axis_pitch_rate;
    logic signed [15:0] axis_yaw_rate;

    modport source (
        output valid, joy_present, axis_forward, axis_left, axis_up,
               axis_pitch_rate, axis_yaw_rate,
        input  ready
    );
    modport sink (
        input  valid, joy_present, axis_forward, axis_left, axis_up,
               axis_pitch_rate, axis_yaw_rate,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/jpi_out_if.sv @@
`default_nettype none
interface jpi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (
        output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/joystick_pose_integrator.sv @@
// Joystick pose integrator.
// Input channel i_in carries one tick item: a joystick-present flag and five
// Q1.15 axes. Output channel o_out carries the Q16.16 position and the Q1.15
// orientation quaternion. An item is moved when valid and ready are both high.
// Until a tick with joy_present set has arrived, ticks are taken and dropped,
// one per cycle. After that, every tick gives exactly one result item.
// Each tick runs three sine/cosine evaluations and thirteen further products
// through a single shared 34x34 multiplier; the series divisions by small
// constants reuse the same multiplier with a reciprocal. A tick is worked
// through to its result in the output register before the next is taken.
// i_in.ready is high only while the sequencer is idle.
// The result sits in an output register; the next tick is accepted while it
// waits, and a new result is held back until the previous one is taken, which
// keeps the input stalled for as long as the receiver holds off.
// Reset (synchronous, active low) restores the register defaults, clears the
// pose and drops any pending result. Configuration writes are made while idle;
// writing an init register also reloads the matching position or heading.
`default_nettype none
module joystick_pose_integrator
    import jpi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    jpi_in_if.sink      i_in,
    jpi_out_if.source   o_out
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_TR_LOAD,
        S_TR_RED,
        S_TR_FOLD,
        S_TR_SQ,
        S_TR_X2,
        S_TR_HMUL,
        S_TR_HDIV,
        S_TR_DIV,
        S_TR_HT,
        S_TR_SMUL,
        S_TR_SWR,
        S_TR_END,
        S_AX_MUL,
        S_AX_WR,
        S_PO_MUL,
        S_PO_WR,
        S_QU_MUL,
        S_QU_WR,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration and pose state.
    logic [15:0]        r_step_time;
    logic               r_joy_seen;
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [19:0] r_pitch, r_yaw;

    // Latched tick axes.
    logic signed [15:0] r_ax_fwd, r_ax_left, r_ax_up, r_ax_pitch, r_ax_yaw;

    // Sequencer bookkeeping.
    logic [1:0] r_pass;
    logic [1:0] r_red_cnt;
    logic [2:0] r_idx;
    logic [3:0] r_step;

    // Trig datapath.
    t_ang  r_ang;
    logic  r_negc;
    t_q30  r_x, r_x2, r_t;
    logic signed [31:0] r_s;
    logic  r_qneg;
    logic [33:0] r_dvd;

    // Shared multiplier.
    t_q30  mul_a, mul_b;
    t_prod r_prod;

    // Trig results and products.
    logic signed [31:0] r_sy0, r_cy0, r_sp, r_cp, r_sy, r_cy;
    logic signed [31:0] r_tf, r_tl;
    t_prod r_acc;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;

    // Output register.
    logic               r_o_valid;
    logic signed [31:0] r_o_pos_x, r_o_pos_y, r_o_pos_z;
    logic signed [15:0] r_o_qx, r_o_qy, r_o_qz, r_o_qw;

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_o_valid;
    assign o_out.pos_x  = r_o_pos_x;
    assign o_out.pos_y  = r_o_pos_y;
    assign o_out.pos_z  = r_o_pos_z;
    assign o_out.quat_x = r_o_qx;
    assign o_out.quat_y = r_o_qy;
    assign o_out.quat_z = r_o_qz;
    assign o_out.quat_w = r_o_qw;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_TR_SQ: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            S_TR_HMUL: begin
                mul_a = r_x2;
                mul_b = r_t;
            end
            S_TR_DIV: begin
                mul_a = $signed(r_dvd);
                mul_b = horner_recip(r_step);
            end
            S_TR_SMUL: begin
                mul_a = r_x;
                mul_b = r_t;
            end
            S_AX_MUL: begin
                mul_b = {18'd0, r_step_time};
                case (r_idx)
                    3'd0: mul_a = 34'(r_ax_fwd);
                    3'd1: mul_a = 34'(r_ax_left);
                    3'd2: mul_a = 34'(r_ax_up);
                    3'd3: mul_a = 34'(r_ax_pitch);
                    default: mul_a = 34'(r_ax_yaw);
                endcase
            end
            S_PO_MUL: begin
                case (r_idx[1:0])
                    2'd0: begin
                        mul_a = 34'(r_tf);
                        mul_b = 34'(r_cy0);
                    end
                    2'd1: begin
                        mul_a = 34'(r_tl);
                        mul_b = 34'(r_sy0);
                    end
                    2'd2: begin
                        mul_a = 34'(r_tf);
                        mul_b = 34'(r_sy0);
                    end
                    default: begin
                        mul_a = 34'(r_tl);
                        mul_b = 34'(r_cy0);
                    end
                endcase
            end
            S_QU_MUL: begin
                case (r_idx[1:0])
                    2'd0: begin
                        mul_a = -34'(r_sy);
                        mul_b = 34'(r_sp);
                    end
                    2'd1: begin
                        mul_a = 34'(r_cy);
                        mul_b = 34'(r_sp);
                    end
                    2'd2: begin
                        mul_a = 34'(r_sy);
                        mul_b = 34'(r_cp);
                    end
                    default: begin
                        mul_a = 34'(r_cy);
                        mul_b = 34'(r_cp);
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Combinational helpers for the sequencer.
    t_ang  red_a1, red_a2;
    t_ang  fold_a;
    logic  fold_neg;
    t_q30  m_val;
    logic [33:0] dvd_mag;
    t_prod q_full;
    t_q30  q_signed, t_new;
    logic signed [31:0] c_val;
    t_prod d15, d45, po_sum;
    logic signed [33:0] sum34;
    t_prod q45;

    always_comb begin
        red_a1 = (r_ang > PI_Q17) ? r_ang - TWO_PI_Q17 : r_ang;
        red_a2 = (red_a1 < -PI_Q17) ? red_a1 + TWO_PI_Q17 : red_a1;

        if (r_ang > HALF_PI_Q17) begin
            fold_a   = PI_Q17 - r_ang;
            fold_neg = 1'b1;
        end else if (r_ang < -HALF_PI_Q17) begin
            fold_a   = -PI_Q17 - r_ang;
            fold_neg = 1'b1;
        end else begin
            fold_a   = r_ang;
            fold_neg = 1'b0;
        end

        m_val   = mul_q30(r_prod);
        dvd_mag = m_val[33] ? 34'(-m_val) : 34'(m_val);

        // The quotient magnitude comes from the reciprocal product; the sign is
        // put back afterwards so the division truncates toward zero.
        q_full   = r_prod >>> horner_post(r_step);
        q_signed = r_qneg ? -$signed(q_full[33:0]) : $signed(q_full[33:0]);
        t_new    = ONE_Q30 - q_signed;
        c_val    = clamp_q30(r_negc ? -r_t : r_t);

        // Round half up, as a floor of the biased value.
        d15 = (r_prod + 68'sd16384) >>> 15;
        po_sum = (r_idx[1:0] == 2'd1) ? r_acc - r_prod : r_acc + r_prod;
        d45 = (po_sum + (68'sd1 <<< 44)) >>> 45;
        q45 = (r_prod + (68'sd1 <<< 44)) >>> 45;
        sum34 = '0;
        case (r_state)
            S_AX_WR: sum34 = 34'(r_pos_z) + d15[33:0];
            S_PO_WR: sum34 = ((r_idx[1:0] == 2'd1) ? 34'(r_pos_x) : 34'(r_pos_y)) + d45[33:0];
            default: sum34 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_time <= STEP_TIME_RESET;
            r_joy_seen  <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_o_valid   <= 1'b0;
            r_pass      <= '0;
            r_red_cnt   <= '0;
            r_idx       <= '0;
            r_step      <= '0;
        end else begin
            // A result taken while a new one is loaded is handled in S_OUT.
            if (r_o_valid && o_out.ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_ax_fwd   <= i_in.axis_forward;
                        r_ax_left  <= i_in.axis_left;
                        r_ax_up    <= i_in.axis_up;
                        r_ax_pitch <= i_in.axis_pitch_rate;
                        r_ax_yaw   <= i_in.axis_yaw_rate;
                        if (i_in.joy_present) begin
                            r_joy_seen <= 1'b1;
                        end
                        if (i_in.joy_present || r_joy_seen) begin
                            r_pass  <= 2'd0;
                            r_state <= S_TR_LOAD;
                        end
                    end
                end
                S_TR_LOAD: begin
                    case (r_pass)
                        2'd0: r_ang <= 22'($signed({r_yaw, 1'b0}));
                        2'd1: r_ang <= 22'(r_pitch);
                        default: r_ang <= 22'(r_yaw);
                    endcase
                    r_red_cnt <= '0;
                    r_state   <= S_TR_RED;
                end
                S_TR_RED: begin
                    r_ang     <= red_a2;
                    r_red_cnt <= r_red_cnt + 2'd1;
                    if (r_red_cnt == 2'd3) begin
                        r_state <= S_TR_FOLD;
                    end
                end
                S_TR_FOLD: begin
                    r_x     <= 34'(fold_a) <<< 13;
                    r_negc  <= fold_neg;
                    r_state <= S_TR_SQ;
                end
                S_TR_SQ: begin
                    r_state <= S_TR_X2;
                end
                S_TR_X2: begin
                    r_x2    <= m_val;
                    r_t     <= ONE_Q30;
                    r_step  <= '0;
                    r_state <= S_TR_HMUL;
                end
                S_TR_HMUL: begin
                    r_state <= S_TR_HDIV;
                end
                S_TR_HDIV: begin
                    r_qneg  <= m_val[33];
                    r_dvd   <= dvd_mag >> horner_pre(r_step);
                    r_state <= S_TR_DIV;
                end
                S_TR_DIV: begin
                    r_state <= S_TR_HT;
                end
                S_TR_HT: begin
                    r_t <= t_new;
                    if (r_step == LAST_SIN_STEP) begin
                        r_step  <= r_step + 4'd1;
                        r_state <= S_TR_SMUL;
                    end else if (r_step == LAST_COS_STEP) begin
                        r_state <= S_TR_END;
                    end else begin
                        r_step  <= r_step + 4'd1;
                        r_state <= S_TR_HMUL;
                    end
                end
                S_TR_SMUL: begin
                    r_state <= S_TR_SWR;
                end
                S_TR_SWR: begin
                    r_s     <= clamp_q30(m_val);
                    r_t     <= ONE_Q30;
                    r_state <= S_TR_HMUL;
                end
                S_TR_END: begin
                    case (r_pass)
                        2'd0: begin
                            r_sy0   <= r_s;
                            r_cy0   <= c_val;
                            r_idx   <= '0;
                            r_state <= S_AX_MUL;
                        end
                        2'd1: begin
                            r_sp    <= r_s;
                            r_cp    <= c_val;
                            r_pass  <= 2'd2;
                            r_state <= S_TR_LOAD;
                        end
                        default: begin
                            r_sy    <= r_s;
                            r_cy    <= c_val;
                            r_idx   <= '0;
                            r_state <= S_QU_MUL;
                        end
                    endcase
                end
                S_AX_MUL: begin
                    r_state <= S_AX_WR;
                end
                S_AX_WR: begin
                    case (r_idx)
                        3'd0: r_tf <= r_prod[31:0];
                        3'd1: r_tl <= r_prod[31:0];
                        3'd2: r_pos_z <= sat32(sum34);
                        3'd3: r_pitch <= wrap_once(22'(r_pitch) + d15[21:0]);
                        default: r_yaw <= wrap_once(22'(r_yaw) + d15[21:0]);
                    endcase
                    if (r_idx == 3'd4) begin
                        r_idx   <= '0;
                        r_state <= S_PO_MUL;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_AX_MUL;
                    end
                end
                S_PO_MUL: begin
                    r_state <= S_PO_WR;
                end
                S_PO_WR: begin
                    case (r_idx[1:0])
                        2'd0: r_acc <= r_prod;
                        2'd1: r_pos_x <= sat32(sum34);
                        2'd2: r_acc <= r_prod;
                        default: r_pos_y <= sat32(sum34);
                    endcase
                    if (r_idx[1:0] == 2'd3) begin
                        r_pass  <= 2'd1;
                        r_state <= S_TR_LOAD;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_PO_MUL;
                    end
                end
                S_QU_MUL: begin
                    r_state <= S_QU_WR;
                end
                S_QU_WR: begin
                    case (r_idx[1:0])
                        2'd0: r_qx <= sat16(q45[19:0]);
                        2'd1: r_qy <= sat16(q45[19:0]);
                        2'd2: r_qz <= sat16(q45[19:0]);
                        default: r_qw <= sat16(q45[19:0]);
                    endcase
                    if (r_idx[1:0] == 2'd3) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_QU_MUL;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_pos_x <= r_pos_x;
                        r_o_pos_y <= r_pos_y;
                        r_o_pos_z <= r_pos_z;
                        r_o_qx    <= r_qx;
                        r_o_qy    <= r_qy;
                        r_o_qz    <= r_qz;
                        r_o_qw    <= r_qw;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // The user writes only while the sequencer is idle; not enforced.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_STEP_TIME:    r_step_time <= i_cfg_data[15:0];
                    REG_INIT_X:       r_pos_x <= i_cfg_data;
                    REG_INIT_Y:       r_pos_y <= i_cfg_data;
                    REG_INIT_Z:       r_pos_z <= i_cfg_data;
                    REG_INIT_HEADING: r_yaw <= 20'($signed(i_cfg_data[18:0]));
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/jpi_checker.sv @@
`default_nettype none
`include "joystick_pose_integrator_assert.svh"
module jpi_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_in_valid,
    input wire         i_in_ready,
    input wire         i_in_joy,
    input wire         i_out_valid,
    input wire         i_out_ready,
    input wire [159:0] i_out_data
);

    `JPI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result item dropped while stalled")
    `JPI_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_data), "stalled result item changed")
    `JPI_ASSERT_NEXT(a_busy_after_tick, i_in_valid && i_in_ready && i_in_joy, !i_in_ready, "input still ready after a joystick tick")
    `JPI_ASSERT_NOW(a_result_from_work, $rose(i_out_valid), !$past(i_in_ready), "result item appeared without work")

endmodule

bind joystick_pose_integrator jpi_checker u_jpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_joy    (i_in.joy_present),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.pos_x, o_out.pos_y, o_out.pos_z, o_out.quat_x,
                   o_out.quat_y, o_out.quat_z, o_out.quat_w})
);
`default_nettype wire
